FILE: rtl/sbnf_pkg.sv
// Package for the stereo biquad notch filter.
// Holds fixed-point formats, coefficient reset values and register indexes.
// No dependencies.
`default_nettype none

package sbnf_pkg;

	// Coefficient format: signed Q2.16
	localparam int COEF_BITS = 18;
	localparam int COEF_FRAC = 16;

	// Output history format: signed Q2.30
	localparam int Y_BITS = 32;
	localparam int Y_FRAC = 30;

	// Accumulator keeps the low bits of the full-precision sum (46 fraction bits)
	localparam int ACC_BITS = Y_BITS + COEF_FRAC;

	// Default sample width (Q1.23)
	localparam int DEFAULT_SAMPLE_BITS = 24;

	// Configuration port
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = COEF_BITS;

	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
	typedef logic signed [COEF_BITS-1:0] coef_t;

	localparam cfg_index_t REG_COEF_B1 = 2'd0;
	localparam cfg_index_t REG_COEF_A1 = 2'd1;
	localparam cfg_index_t REG_COEF_A2 = 2'd2;

	// Reset coefficients of the 60 Hz notch
	localparam coef_t COEF_B1_RESET = -18'sd131068;
	localparam coef_t COEF_A1_RESET = -18'sd131029;
	localparam coef_t COEF_A2_RESET = 18'sd65496;

endpackage

`default_nettype wire

FILE: rtl/stereo_biquad_notch_filter.sv
// Stereo second-order Direct Form I notch filter, top level.
// Depends on sbnf_pkg for formats, reset coefficients and register indexes.
// Usage:
//   Input channel (in_valid/in_ready) carries one signed sample and a
//   left_channel flag selecting the left (1) or right (0) history. The
//   output channel (out_valid/out_ready) returns one filtered sample per
//   input transaction, in order.
//   Path: a sample accepted into the input stage is filtered and lands in
//   the output register when the input stage advances, which sets
//   out_valid; a full, stalled output register holds it back.
//   Throughput: one sample per cycle unless stalled. Three parallel
//   18x32 multiplies and one 48-bit sum sit between the input stage and
//   the output register; history updates on the edge that loads it, so a
//   following sample of the same channel sees it without stalls.
//   Stall: while out_ready is low the output register holds its result,
//   one more sample waits in the input stage and in_ready drops.
//   Reset (arst_n low): both histories clear to zero, coefficients return
//   to the notch defaults, both stages empty.
//   The user must write coefficients through cfg_we/cfg_index/cfg_data
//   only while idle; the block does not enforce it. Index 3 is ignored.
`default_nettype none

module stereo_biquad_notch_filter
	import sbnf_pkg::*;
#(
	parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write port
	input  wire logic                          cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]      cfg_data,
	// input samples
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
	input  wire logic                          left_channel,
	// filtered samples
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0]      sample_out
);

	// Shift between sample format and Q2.30, either direction
	localparam int SH_UP   = (SAMPLE_BITS <= Y_FRAC + 1) ? (Y_FRAC + 1 - SAMPLE_BITS) : 0;
	localparam int SH_DOWN = (SAMPLE_BITS >  Y_FRAC + 1) ? (SAMPLE_BITS - Y_FRAC - 1) : 0;
	localparam int PROD_BITS = COEF_BITS + Y_BITS;

	// Sample (Q1.n) to Q2.30, floored when the sample has more fraction bits
	function automatic logic signed [Y_BITS-1:0] to_q30(
		input logic signed [SAMPLE_BITS-1:0] v
	);
		if (SAMPLE_BITS <= Y_FRAC + 1) begin
			to_q30 = Y_BITS'(v) <<< SH_UP;
		end else begin
			to_q30 = Y_BITS'(v >>> SH_DOWN);
		end
	endfunction

	// Q2.30 to sample format, floored and wrapped
	function automatic logic signed [SAMPLE_BITS-1:0] to_sample(
		input logic signed [Y_BITS-1:0] v
	);
		if (SAMPLE_BITS <= Y_FRAC + 1) begin
			to_sample = SAMPLE_BITS'(v >>> SH_UP);
		end else begin
			to_sample = SAMPLE_BITS'(v <<< SH_DOWN);
		end
	endfunction

	// Coefficient registers
	coef_t coef_b1_q;
	coef_t coef_a1_q;
	coef_t coef_a2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b1_q <= COEF_B1_RESET;
			coef_a1_q <= COEF_A1_RESET;
			coef_a2_q <= COEF_A2_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEF_B1: coef_b1_q <= coef_t'(cfg_data);
				REG_COEF_A1: coef_a1_q <= coef_t'(cfg_data);
				REG_COEF_A2: coef_a2_q <= coef_t'(cfg_data);
				default: ;
			endcase
		end
	end

	// Input stage
	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          chan_s1;
	logic                          advance;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample_in;
			chan_s1   <= left_channel;
		end
	end

	// Per-channel history, index 0 right, 1 left
	logic signed [SAMPLE_BITS-1:0] x1_q [2];
	logic signed [SAMPLE_BITS-1:0] x2_q [2];
	logic signed [Y_BITS-1:0]      y1_q [2];
	logic signed [Y_BITS-1:0]      y2_q [2];

	// Filter datapath
	logic signed [SAMPLE_BITS-1:0] x1_cur;
	logic signed [SAMPLE_BITS-1:0] x2_cur;
	logic signed [Y_BITS-1:0]      y1_cur;
	logic signed [Y_BITS-1:0]      y2_cur;
	logic signed [Y_BITS-1:0]      x0_q30;
	logic signed [Y_BITS-1:0]      x1_q30;
	logic signed [Y_BITS-1:0]      x2_q30;
	logic signed [PROD_BITS-1:0]   prod_b1;
	logic signed [PROD_BITS-1:0]   prod_a1;
	logic signed [PROD_BITS-1:0]   prod_a2;
	logic [ACC_BITS-1:0]           acc;
	logic signed [Y_BITS-1:0]      y_new;

	assign x1_cur = x1_q[chan_s1];
	assign x2_cur = x2_q[chan_s1];
	assign y1_cur = y1_q[chan_s1];
	assign y2_cur = y2_q[chan_s1];

	assign x0_q30 = to_q30(sample_s1);
	assign x1_q30 = to_q30(x1_cur);
	assign x2_q30 = to_q30(x2_cur);

	assign prod_b1 = coef_b1_q * x1_q30;
	assign prod_a1 = coef_a1_q * y1_cur;
	assign prod_a2 = coef_a2_q * y2_cur;

	// Sum modulo 2^48; y is bits [47:16], which floors and wraps to Q2.30
	assign acc = {x0_q30, {COEF_FRAC{1'b0}}}
		+ prod_b1[ACC_BITS-1:0]
		+ {x2_q30, {COEF_FRAC{1'b0}}}
		- prod_a1[ACC_BITS-1:0]
		- prod_a2[ACC_BITS-1:0];

	assign y_new = $signed(acc[ACC_BITS-1 -: Y_BITS]);

	// History update on the edge the result is registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				x1_q[i] <= '0;
				x2_q[i] <= '0;
				y1_q[i] <= '0;
				y2_q[i] <= '0;
			end
		end else if (advance) begin
			x2_q[chan_s1] <= x1_cur;
			x1_q[chan_s1] <= sample_s1;
			y2_q[chan_s1] <= y1_cur;
			y1_q[chan_s1] <= y_new;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sample_out <= to_sample(y_new);
		end
	end

endmodule

`default_nettype wire
